// ===== rtl/vga_crtc_register_bank_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef VGA_CRTC_REGISTER_BANK_UNIT_MACROS_SVH
`define VGA_CRTC_REGISTER_BANK_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VCRB_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define VCRB_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ===== rtl/vcrb_pkg.sv =====
// Package with the access codes and payload types of the CRTC register bank.
package vcrb_pkg;
   typedef enum logic [1:0] {
      ACT_WR_INDEX = 2'd0,
      ACT_RD_INDEX = 2'd1,
      ACT_WR_DATA  = 2'd2,
      ACT_RD_DATA  = 2'd3
   } action_type;

   localparam logic [7:0] UNLOCK_KEY = 8'h48;
   localparam logic [7:0] ID_2D = 8'h88;
   localparam logic [7:0] ID_2E = 8'h11;
   localparam logic [7:0] ID_2F = 8'h80;
   localparam logic [7:0] ID_30 = 8'he0;
   localparam logic [7:0] ID_36 = 8'h8f;
   localparam logic [7:0] ID_37 = 8'h2b;
   localparam int RSP_BITS = 8 + 5 + 11 + 21 + 10 + 16 + 6 + 1;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   typedef struct packed {
      logic        unknown_index;
      logic [5:0]  memory_bank;
      logic [15:0] cursor_address;
      logic [9:0]  scan_length;
      logic [20:0] start_address;
      logic [10:0] split_line;
      logic        window_request;
      logic        scan_length_request;
      logic        mode_request;
      logic        remap_request;
      logic        resize_request;
      logic [7:0]  read_data;
   } rsp_type;
endpackage

// ===== rtl/vga_crtc_register_bank_unit.sv =====
// Top level: CRTC index/data register bank with extended registers.
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one access per cycle; the single output register stalls only when
// the result is not taken, and a new word is accepted as the old one leaves.
// Reset: synchronous, active high; clears the index, all registers and the
// assembled values, and empties the output register.
module vga_crtc_register_bank_unit
   import vcrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [1:0] action, [9:2] write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [RSP_BYTES*8-1:0] rsp_tdata // read_data, resize, remap, mode,
                                            // scan, window requests, split_line,
                                            // start_address, scan_length,
                                            // cursor_address, memory_bank, unknown
);
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  std_ff [25];
   logic [7:0]  std_in [25];
   logic        lock_ff, lock_in;
   logic [7:0]  x31_ff, x35_ff, x38_ff, x39_ff, x43_ff, x51_ff, x55_ff, x58_ff;
   logic [7:0]  x5d_ff, x5e_ff, x67_ff;
   logic [7:0]  x31_in, x35_in, x38_in, x39_in, x43_in, x51_in, x55_in, x58_in;
   logic [7:0]  x5d_in, x5e_in, x67_in;
   logic [15:0] win_ff, win_in;
   logic [5:0]  bank_ff, bank_in;
   logic [10:0] split_ff, split_in;
   logic [20:0] start_ff, start_in;
   logic [9:0]  scan_ff, scan_in;
   logic [15:0] cur_ff, cur_in;
   logic        vld_ff, vld_in;
   rsp_type     rsp_ff, rsp_in;
   logic        accept;
   action_type  act;
   logic [7:0]  v;
   logic [7:0]  rd;
   logic        f_resize, f_remap, f_mode, f_scan, f_window, f_unknown;
   logic [4:0]  sidx;

   assign req_tready = !vld_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign act = action_type'(req_tdata[1:0]);
   assign v = req_tdata[9:2];
   assign sidx = idx_ff[4:0];
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {{(RSP_BYTES*8-RSP_BITS){1'b0}}, rsp_ff};

   // Decode one access and compute the next register contents.
   always_comb begin
      idx_in = idx_ff; std_in = std_ff; lock_in = lock_ff;
      x31_in = x31_ff; x35_in = x35_ff; x38_in = x38_ff; x39_in = x39_ff;
      x43_in = x43_ff; x51_in = x51_ff; x55_in = x55_ff; x58_in = x58_ff;
      x5d_in = x5d_ff; x5e_in = x5e_ff; x67_in = x67_ff;
      win_in = win_ff; bank_in = bank_ff; split_in = split_ff;
      start_in = start_ff; scan_in = scan_ff; cur_in = cur_ff;
      rd = 8'h00;
      f_resize = 1'b0; f_remap = 1'b0; f_mode = 1'b0;
      f_scan = 1'b0; f_window = 1'b0; f_unknown = 1'b0;
      case (act)
         ACT_WR_INDEX: idx_in = v;
         ACT_RD_INDEX: rd = idx_ff;
         ACT_WR_DATA: begin
            if (idx_ff <= 8'h18) begin
               if (idx_ff == 8'h07) split_in[8] = v[4];
               if (!(idx_ff <= 8'h07 && lock_ff)) begin
                  std_in[sidx] = v;
                  case (idx_ff)
                     8'h01, 8'h06, 8'h12, 8'h15: f_resize = std_ff[sidx] != v;
                     8'h07: f_resize = |((std_ff[sidx] ^ v) & 8'hd6);
                     8'h09: begin
                        split_in[9] = v[6];
                        f_resize = |((std_ff[sidx] ^ v) & 8'hbf);
                     end
                     8'h0c: start_in[15:8] = v;
                     8'h0d: start_in[7:0] = v;
                     8'h0e: cur_in[15:8] = v;
                     8'h0f: cur_in[7:0] = v;
                     8'h11: lock_in = v[7];
                     8'h13: begin scan_in[7:0] = v; f_scan = 1'b1; end
                     8'h17: f_mode = 1'b1;
                     8'h18: split_in[7:0] = v;
                     default: ;
                  endcase
               end
            end else begin
               case (idx_ff)
                  8'h31: x31_in = v;
                  8'h35: if (x38_ff == UNLOCK_KEY) begin
                     x35_in = {v[7:4], 4'h0};
                     if (bank_ff[3:0] != v[3:0]) begin
                        bank_in[3:0] = v[3:0]; f_remap = 1'b1;
                     end
                  end
                  8'h38: x38_in = v;
                  8'h39: x39_in = v;
                  8'h43: begin
                     x43_in = v & 8'hfb;
                     if (v[2] != scan_ff[8]) begin
                        scan_in[8] = v[2]; f_scan = 1'b1;
                     end
                  end
                  8'h51: begin
                     x51_in = v & 8'hc0;
                     start_in[17:16] = v[1:0];
                     if (v[3:2] != bank_ff[5:4]) begin
                        bank_in[5:4] = v[3:2]; f_remap = 1'b1;
                     end
                     if (v[5:4] != scan_ff[9:8]) begin
                        scan_in[9:8] = v[5:4]; f_scan = 1'b1;
                     end
                  end
                  8'h55: x55_in = v;
                  8'h58: x58_in = v;
                  8'h59: if (win_ff[15:8] != v) begin
                     win_in[15:8] = v; f_window = 1'b1;
                  end
                  8'h5a: if (win_ff[7:0] != v) begin
                     win_in[7:0] = v; f_window = 1'b1;
                  end
                  8'h5d: begin
                     f_resize = x5d_ff[1:0] != v[1:0]; x5d_in = v;
                  end
                  8'h5e: begin
                     split_in[10] = v[6];
                     f_resize = x5e_ff[1:0] != v[1:0]; x5e_in = v;
                  end
                  8'h67: begin x67_in = v; f_mode = 1'b1; end
                  8'h69: start_in[20:16] = v[4:0];
                  8'h6a: begin bank_in = v[5:0]; f_remap = 1'b1; end
                  default: f_unknown = 1'b1;
               endcase
            end
         end
         ACT_RD_DATA: begin
            if (idx_ff <= 8'h18) rd = std_ff[sidx];
            else begin
               case (idx_ff)
                  8'h2d: rd = ID_2D;
                  8'h2e: rd = ID_2E;
                  8'h2f: rd = ID_2F;
                  8'h30: rd = ID_30;
                  8'h31: rd = x31_ff;
                  8'h35: rd = x35_ff | {4'h0, bank_ff[3:0]};
                  8'h36: rd = ID_36;
                  8'h37: rd = ID_37;
                  8'h38: rd = x38_ff;
                  8'h39: rd = x39_ff;
                  8'h43: rd = x43_ff | {5'h0, scan_ff[8], 2'b00};
                  8'h51: rd = x51_ff | {2'b00, scan_ff[9:8], bank_ff[5:4],
                                        start_ff[17:16]};
                  8'h55: rd = x55_ff;
                  8'h58: rd = x58_ff;
                  8'h5d: rd = x5d_ff;
                  8'h5e: rd = x5e_ff;
                  8'h67: rd = x67_ff;
                  8'h69: rd = {3'b000, start_ff[20:16]};
                  8'h6a: rd = {2'b00, bank_ff};
                  default: f_unknown = 1'b1;
               endcase
            end
         end
         default: ;
      endcase
      rsp_in.read_data = rd;
      rsp_in.resize_request = f_resize;
      rsp_in.remap_request = f_remap;
      rsp_in.mode_request = f_mode;
      rsp_in.scan_length_request = f_scan;
      rsp_in.window_request = f_window;
      rsp_in.split_line = split_in;
      rsp_in.start_address = start_in;
      rsp_in.scan_length = scan_in;
      rsp_in.cursor_address = cur_in;
      rsp_in.memory_bank = bank_in;
      rsp_in.unknown_index = f_unknown;
      vld_in = accept || (vld_ff && !rsp_tready);
   end

   // Register state and output word.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0; lock_ff <= 1'b0;
         for (int i = 0; i < 25; i++) std_ff[i] <= '0;
         x31_ff <= '0; x35_ff <= '0; x38_ff <= '0; x39_ff <= '0; x43_ff <= '0;
         x51_ff <= '0; x55_ff <= '0; x58_ff <= '0; x5d_ff <= '0; x5e_ff <= '0;
         x67_ff <= '0;
         win_ff <= '0; bank_ff <= '0; split_ff <= '0; start_ff <= '0;
         scan_ff <= '0; cur_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (accept) begin
            idx_ff <= idx_in; std_ff <= std_in; lock_ff <= lock_in;
            x31_ff <= x31_in; x35_ff <= x35_in; x38_ff <= x38_in; x39_ff <= x39_in;
            x43_ff <= x43_in; x51_ff <= x51_in; x55_ff <= x55_in; x58_ff <= x58_in;
            x5d_ff <= x5d_in; x5e_ff <= x5e_in; x67_ff <= x67_in;
            win_ff <= win_in; bank_ff <= bank_in; split_ff <= split_in;
            start_ff <= start_in; scan_ff <= scan_in; cur_ff <= cur_in;
         end
      end
      if (accept) rsp_ff <= rsp_in;
   end
endmodule

// ===== rtl/vcrb_checker.sv =====
// Port-level checker for the CRTC register bank, bound to the top level.
`include "vga_crtc_register_bank_unit_macros.svh"
module vcrb_checker
   import vcrb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [RSP_BYTES*8-1:0] rsp_tdata
);
   `VCRB_ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready, rsp_tvalid, "no result after accepted request")
   `VCRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `VCRB_ASSERT_IMP(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "not ready while output empty")
   `VCRB_ASSERT_NEXT(a_idx_write_quiet, clock, reset, req_tvalid && req_tready && req_tdata[1:0] == 2'd0, rsp_tdata[12:0] == 13'd0 && !rsp_tdata[77], "index write raised flags")
endmodule

bind vga_crtc_register_bank_unit vcrb_checker u_vcrb_checker (.*);
